// ===== hdl/sc_pkg.sv =====
// ----------------------------------------------------------------------------
// sc_pkg - stack calculator shared definitions
// Operation and status codes, sequencer and arithmetic unit types.
// ----------------------------------------------------------------------------
package sc_pkg;

   localparam int OP_WIDTH     = 4;
   localparam int IDX_WIDTH    = 4;
   localparam int STATUS_WIDTH = 3;

   localparam int DEC_AMOUNT = 2;
   localparam int INC_AMOUNT = 3;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_PUSH = 4'd0,
      OP_POP  = 4'd1,
      OP_PEEK = 4'd2,
      OP_DEC2 = 4'd3,
      OP_ADD3 = 4'd4,
      OP_ADD  = 4'd5,
      OP_SUB  = 4'd6,
      OP_MUL  = 4'd7,
      OP_DIV  = 4'd8,
      OP_SWAP = 4'd9
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 3'd0,
      ST_FEW   = 3'd1,
      ST_FULL  = 3'd2,
      ST_DIVZ  = 3'd3,
      ST_RANGE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DECODE,
      SEQ_READ_X,
      SEQ_READ_Y,
      SEQ_SWAP_B,
      SEQ_CALC
   } seq_state_type;

   typedef enum logic [1:0] {
      ALU_IDLE,
      ALU_ITER,
      ALU_FINISH
   } alu_state_type;

   typedef enum logic [1:0] {
      AOP_ADD,
      AOP_SUB,
      AOP_MUL,
      AOP_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

endpackage

// ===== hdl/sc_stack_ram.sv =====
// ----------------------------------------------------------------------------
// sc_stack_ram - stack word storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sc_stack_ram #(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sc_alu.sv =====
// ----------------------------------------------------------------------------
// sc_alu - shared iterative arithmetic unit
// Add/subtract in one step; multiply by shift-add and signed divide by
// restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module sc_alu #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sc_pkg::alu_req_type   req,
   input  logic [DATA_WIDTH-1:0] opa,
   input  logic [DATA_WIDTH-1:0] opb,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] result
);

   import sc_pkg::*;

   localparam int IW = $clog2(DATA_WIDTH + 1);

   alu_state_type         state_ff, state_in;
   alu_op_type            kind_ff, kind_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] sa_ff, sa_in;   // multiplicand / divisor magnitude
   logic [DATA_WIDTH-1:0] sb_ff, sb_in;   // multiplier / dividend -> quotient
   logic                  neg_ff, neg_in;
   logic [IW-1:0]         iter_ff, iter_in;

   logic [DATA_WIDTH-1:0] shifted;
   logic                  fits;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ALU_IDLE: begin
            if (req.start) begin
               if (req.op == AOP_ADD || req.op == AOP_SUB) begin
                  state_in = ALU_FINISH;
               end else begin
                  state_in = ALU_ITER;
               end
            end
         end
         ALU_ITER: begin
            if (iter_ff == IW'(1)) begin
               state_in = ALU_FINISH;
            end
         end
         ALU_FINISH: state_in = ALU_IDLE;
         default:    state_in = ALU_IDLE;
      endcase
   end

   assign shifted = {acc_ff[DATA_WIDTH-2:0], sb_ff[DATA_WIDTH-1]};
   assign fits    = (shifted >= sa_ff);

   // datapath
   always_comb begin
      kind_in = kind_ff;
      acc_in  = acc_ff;
      sa_in   = sa_ff;
      sb_in   = sb_ff;
      neg_in  = neg_ff;
      iter_in = iter_ff;
      case (state_ff)
         ALU_IDLE: begin
            if (req.start) begin
               kind_in = req.op;
               iter_in = IW'(DATA_WIDTH);
               case (req.op)
                  AOP_ADD: acc_in = opa + opb;
                  AOP_SUB: acc_in = opa - opb;
                  AOP_MUL: begin
                     acc_in = '0;
                     sa_in  = opa;
                     sb_in  = opb;
                  end
                  AOP_DIV: begin
                     acc_in = '0;
                     sa_in  = opb[DATA_WIDTH-1] ? '0 - opb : opb;
                     sb_in  = opa[DATA_WIDTH-1] ? '0 - opa : opa;
                     neg_in = opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
                  end
                  default: acc_in = '0;
               endcase
            end
         end
         ALU_ITER: begin
            iter_in = iter_ff - IW'(1);
            if (kind_ff == AOP_MUL) begin
               if (sb_ff[0]) begin
                  acc_in = acc_ff + sa_ff;
               end
               sa_in = {sa_ff[DATA_WIDTH-2:0], 1'b0};
               sb_in = {1'b0, sb_ff[DATA_WIDTH-1:1]};
            end else begin
               acc_in = fits ? shifted - sa_ff : shifted;
               sb_in  = {sb_ff[DATA_WIDTH-2:0], fits};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
      acc_ff  <= acc_in;
      sa_ff   <= sa_in;
      sb_ff   <= sb_in;
      neg_ff  <= neg_in;
      iter_ff <= iter_in;
   end

   assign done   = (state_ff == ALU_FINISH);
   assign result = (kind_ff != AOP_DIV) ? acc_ff : (neg_ff ? '0 - sb_ff : sb_ff);

endmodule

// ===== hdl/stack_calculator.sv =====
// ----------------------------------------------------------------------------
// stack_calculator - stack of signed words with arithmetic operations
// Sequencer over a one-read/one-write stack RAM and a shared iterative ALU.
// ----------------------------------------------------------------------------
// From start to rsp_valid: push, unused codes and DECODE errors answer
// there; pop/peek from READ_X; dec2/add3 via READ_X and CALC; divide by zero
// from READ_Y; swap via READ_Y and SWAP_B; add/sub via READ_Y and CALC, and
// mul/div too, iterating there one bit per cycle. The next start is taken in
// the rsp_valid cycle. Synchronous reset empties the stack; no clearing pass.
// rsp_valid is a single-cycle strobe and the receiver cannot stall.
module stack_calculator #(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [sc_pkg::OP_WIDTH-1:0]     req_op,
   input  logic [DATA_WIDTH-1:0]           req_value,
   input  logic [sc_pkg::IDX_WIDTH-1:0]    req_index_a,
   input  logic [sc_pkg::IDX_WIDTH-1:0]    req_index_b,
   output logic                            rsp_valid,
   output logic [DATA_WIDTH-1:0]           rsp_result_value,
   output logic [sc_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic                            rsp_is_empty,
   output logic                            rsp_is_full,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_element_count
);

   import sc_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   seq_state_type         state_ff, state_in;
   op_type                op_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [IDX_WIDTH-1:0]  ia_ff, ib_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] x_ff, x_in;

   logic                  finish;
   logic [DATA_WIDTH-1:0] result_in;
   status_type            status_in;

   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_result_ff;
   status_type            rsp_status_ff;
   logic                  rsp_empty_ff, rsp_full_ff;
   logic [CW-1:0]         rsp_count_ff;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;

   alu_req_type           alu_req;
   logic [DATA_WIDTH-1:0] alu_opa, alu_opb, alu_result;
   logic                  alu_done;

   logic [CW-1:0]         count_m1, count_m2;
   logic [AW-1:0]         top_addr, next_addr;
   logic                  is_unary, is_binary;
   logic                  full, few_unary, few_binary, swap_bad, divz;
   alu_op_type            bin_aop;

   assign count_m1   = count_ff - CW'(1);
   assign count_m2   = count_ff - CW'(2);
   assign top_addr   = count_m1[AW-1:0];
   assign next_addr  = count_m2[AW-1:0];
   assign is_unary   = op_ff inside {OP_DEC2, OP_ADD3};
   assign is_binary  = op_ff inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
   assign full       = (count_ff == CW'(DEPTH));
   assign few_unary  = (count_ff == '0);
   assign few_binary = (count_ff < CW'(2));
   assign swap_bad   = (32'(ia_ff) >= 32'(count_ff)) || (32'(ib_ff) >= 32'(count_ff));
   assign divz       = (rd_data == '0);

   always_comb begin
      case (op_ff)
         OP_ADD:  bin_aop = AOP_ADD;
         OP_SUB:  bin_aop = AOP_SUB;
         OP_MUL:  bin_aop = AOP_MUL;
         default: bin_aop = AOP_DIV;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_DECODE;
            end
         end
         SEQ_DECODE: begin
            case (op_ff)
               OP_POP, OP_PEEK, OP_DEC2, OP_ADD3:
                  state_in = few_unary ? SEQ_IDLE : SEQ_READ_X;
               OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                  state_in = few_binary ? SEQ_IDLE : SEQ_READ_X;
               OP_SWAP:
                  state_in = swap_bad ? SEQ_IDLE : SEQ_READ_X;
               default:
                  state_in = SEQ_IDLE;
            endcase
         end
         SEQ_READ_X: begin
            if (is_unary) begin
               state_in = SEQ_CALC;
            end else if (is_binary || op_ff == OP_SWAP) begin
               state_in = SEQ_READ_Y;
            end else begin
               state_in = SEQ_IDLE;
            end
         end
         SEQ_READ_Y: begin
            if (op_ff == OP_SWAP) begin
               state_in = SEQ_SWAP_B;
            end else if (op_ff == OP_DIV && divz) begin
               state_in = SEQ_IDLE;
            end else begin
               state_in = SEQ_CALC;
            end
         end
         SEQ_SWAP_B: state_in = SEQ_IDLE;
         SEQ_CALC: begin
            if (alu_done) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      count_in  = count_ff;
      x_in      = x_ff;
      finish    = 1'b0;
      result_in = '0;
      status_in = ST_OK;
      wr_en     = 1'b0;
      wr_addr   = top_addr;
      wr_data   = alu_result;
      rd_addr   = top_addr;
      alu_req   = '{start: 1'b0, op: AOP_ADD};
      alu_opa   = x_ff;
      alu_opb   = rd_data;
      case (state_ff)
         SEQ_DECODE: begin
            case (op_ff)
               OP_PUSH: begin
                  finish = 1'b1;
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     wr_data  = value_ff;
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_POP, OP_PEEK, OP_DEC2, OP_ADD3: begin
                  if (few_unary) begin
                     finish    = 1'b1;
                     status_in = ST_FEW;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (few_binary) begin
                     finish    = 1'b1;
                     status_in = ST_FEW;
                  end
               end
               OP_SWAP: begin
                  rd_addr = AW'(ia_ff);
                  if (swap_bad) begin
                     finish    = 1'b1;
                     status_in = ST_RANGE;
                  end
               end
               default: finish = 1'b1;
            endcase
         end
         SEQ_READ_X: begin
            x_in = rd_data;
            case (op_ff)
               OP_POP: begin
                  finish    = 1'b1;
                  result_in = rd_data;
                  count_in  = count_m1;
               end
               OP_PEEK: begin
                  finish    = 1'b1;
                  result_in = rd_data;
               end
               OP_DEC2: begin
                  alu_req = '{start: 1'b1, op: AOP_SUB};
                  alu_opa = rd_data;
                  alu_opb = DATA_WIDTH'(DEC_AMOUNT);
               end
               OP_ADD3: begin
                  alu_req = '{start: 1'b1, op: AOP_ADD};
                  alu_opa = rd_data;
                  alu_opb = DATA_WIDTH'(INC_AMOUNT);
               end
               OP_SWAP: rd_addr = AW'(ib_ff);
               default: rd_addr = next_addr;
            endcase
         end
         SEQ_READ_Y: begin
            if (op_ff == OP_SWAP) begin
               wr_en   = 1'b1;
               wr_addr = AW'(ia_ff);
               wr_data = rd_data;
            end else if (op_ff == OP_DIV && divz) begin
               finish    = 1'b1;
               status_in = ST_DIVZ;
            end else begin
               alu_req = '{start: 1'b1, op: bin_aop};
            end
         end
         SEQ_SWAP_B: begin
            finish  = 1'b1;
            wr_en   = 1'b1;
            wr_addr = AW'(ib_ff);
            wr_data = x_ff;
         end
         SEQ_CALC: begin
            if (alu_done) begin
               finish    = 1'b1;
               wr_en     = 1'b1;
               wr_addr   = is_binary ? next_addr : top_addr;
               result_in = alu_result;
               if (is_binary) begin
                  count_in = count_m1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= finish;
      end
      if (state_ff == SEQ_IDLE && start) begin
         op_ff    <= op_type'(req_op);
         value_ff <= req_value;
         ia_ff    <= req_index_a;
         ib_ff    <= req_index_b;
      end
      x_ff <= x_in;
      if (finish) begin
         rsp_result_ff <= result_in;
         rsp_status_ff <= status_in;
         rsp_empty_ff  <= (count_in == '0);
         rsp_full_ff   <= (count_in == CW'(DEPTH));
         rsp_count_ff  <= count_in;
      end
   end

   sc_stack_ram #(
      .DATA_WIDTH (DATA_WIDTH),
      .DEPTH      (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sc_alu #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .opa    (alu_opa),
      .opb    (alu_opb),
      .done   (alu_done),
      .result (alu_result)
   );

   assign busy              = (state_ff != SEQ_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_value  = rsp_result_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_is_full       = rsp_full_ff;
   assign rsp_element_count = rsp_count_ff;

endmodule

// ===== bench/stack_calculator_checker.sv =====
// ----------------------------------------------------------------------------
// stack_calculator_checker - response predictor and comparator
// Watches the command and response channels of the stack calculator, keeps
// its own copy of the stack, predicts the response of every accepted
// transaction and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module stack_calculator_checker #(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [sc_pkg::OP_WIDTH-1:0]     req_op,
   input  logic [DATA_WIDTH-1:0]           req_value,
   input  logic [sc_pkg::IDX_WIDTH-1:0]    req_index_a,
   input  logic [sc_pkg::IDX_WIDTH-1:0]    req_index_b,
   input  logic                            rsp_valid,
   input  logic [DATA_WIDTH-1:0]           rsp_result_value,
   input  logic [sc_pkg::STATUS_WIDTH-1:0] rsp_status,
   input  logic                            rsp_is_empty,
   input  logic                            rsp_is_full,
   input  logic [$clog2(DEPTH+1)-1:0]      rsp_element_count,
   output int                              fail_count,
   output int                              pending,
   output int                              checked
);

   import sc_pkg::*;

   localparam int CW = $clog2(DEPTH+1);

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef struct {
      word_type        value;
      status_type      status;
      logic            empty;
      logic            full;
      logic [CW-1:0]   count;
   } reply_type;

   localparam word_type MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   word_type  stack_words [DEPTH];
   int        stack_depth;
   reply_type replies_due [$];

   // truncating divide; the one overflow case wraps back to the most negative
   function automatic word_type quotient(word_type x, word_type y);
      if (x == MOST_NEG && y == '1) return MOST_NEG;
      return word_type'($signed(x) / $signed(y));
   endfunction

   function automatic reply_type execute_op(logic [OP_WIDTH-1:0] op, word_type operand,
                                            logic [IDX_WIDTH-1:0] ia,
                                            logic [IDX_WIDTH-1:0] ib);
      reply_type r;
      word_type  x;
      word_type  y;
      word_type  t;
      r.value  = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (stack_depth >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               stack_words[stack_depth] = operand;
               stack_depth++;
            end
         end
         OP_POP, OP_PEEK, OP_DEC2, OP_ADD3: begin
            if (stack_depth == 0) begin
               r.status = ST_FEW;
            end else begin
               t = stack_words[stack_depth-1];
               if (op == OP_POP) begin
                  stack_depth--;
               end else if (op == OP_DEC2) begin
                  t = t - word_type'(DEC_AMOUNT);
                  stack_words[stack_depth-1] = t;
               end else if (op == OP_ADD3) begin
                  t = t + word_type'(INC_AMOUNT);
                  stack_words[stack_depth-1] = t;
               end
               r.value = t;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (stack_depth < 2) begin
               r.status = ST_FEW;
            end else begin
               x = stack_words[stack_depth-1];
               y = stack_words[stack_depth-2];
               if (op == OP_DIV && y == '0) begin
                  r.status = ST_DIVZ;
               end else begin
                  case (op)
                     OP_ADD:  t = x + y;
                     OP_SUB:  t = x - y;
                     OP_MUL:  t = x * y;
                     default: t = quotient(x, y);
                  endcase
                  stack_words[stack_depth-2] = t;
                  stack_depth--;
                  r.value = t;
               end
            end
         end
         OP_SWAP: begin
            if (ia >= stack_depth || ib >= stack_depth) begin
               r.status = ST_RANGE;
            end else begin
               t               = stack_words[ia];
               stack_words[ia] = stack_words[ib];
               stack_words[ib] = t;
            end
         end
         default: ;  // unused codes leave everything alone
      endcase
      r.empty = (stack_depth == 0);
      r.full  = (stack_depth == DEPTH);
      r.count = CW'(stack_depth);
      return r;
   endfunction

   task automatic log_failure(string what);
      fail_count++;
      if (fail_count <= 10) $display("[%0t] %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      reply_type due;
      if (reset) begin
         stack_depth = 0;
         replies_due.delete();
      end else begin
         // compare first: a response and the next transaction share an edge
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               log_failure($sformatf("response with nothing outstanding: value=%h status=%0d",
                                     rsp_result_value, rsp_status));
            end else begin
               due = replies_due.pop_front();
               checked++;
               if (rsp_result_value !== due.value || rsp_status !== due.status ||
                   rsp_is_empty !== due.empty || rsp_is_full !== due.full ||
                   rsp_element_count !== due.count) begin
                  log_failure($sformatf({"mismatch: expected value=%h status=%0d empty=%b",
                                         " full=%b count=%0d, got value=%h status=%0d",
                                         " empty=%b full=%b count=%0d"},
                                        due.value, due.status, due.empty, due.full,
                                        due.count, rsp_result_value, rsp_status,
                                        rsp_is_empty, rsp_is_full, rsp_element_count));
               end
            end
         end
         if (start && !busy) begin
            replies_due.push_back(execute_op(req_op, req_value, req_index_a,
                                             req_index_b));
         end
      end
      pending = replies_due.size();
   end

endmodule

// ===== bench/stack_calculator_tb.sv =====
// ----------------------------------------------------------------------------
// stack_calculator_tb - testbench top for the stack calculator
// Directed corner cases followed by random phases of push-heavy, pop-heavy
// and mixed traffic with random idle gaps; a separate checker predicts and
// compares every response, and this module reports the verdict.
// ----------------------------------------------------------------------------
module stack_calculator_tb;
   import sc_pkg::*;

   localparam int DATA_WIDTH  = 32;
   localparam int DEPTH       = 16;
   localparam int CW          = $clog2(DEPTH+1);
   localparam int PHASES      = 15;
   localparam int PHASE_ITEMS = 100;

   typedef logic [DATA_WIDTH-1:0] word_type;

   localparam word_type MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam word_type MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    start       = 1'b0;
   logic [OP_WIDTH-1:0]     req_op      = '0;
   word_type                req_value   = '0;
   logic [IDX_WIDTH-1:0]    req_index_a = '0;
   logic [IDX_WIDTH-1:0]    req_index_b = '0;
   logic                    busy;
   logic                    rsp_valid;
   word_type                rsp_result_value;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic                    rsp_is_empty;
   logic                    rsp_is_full;
   logic [CW-1:0]           rsp_element_count;
   int                      fail_count;
   int                      pending;
   int                      checked;
   int                      sent = 0;

   always #4 clock = ~clock;

   stack_calculator #(
      .DATA_WIDTH (DATA_WIDTH),
      .DEPTH      (DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_value         (req_value),
      .req_index_a       (req_index_a),
      .req_index_b       (req_index_b),
      .rsp_valid         (rsp_valid),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .rsp_element_count (rsp_element_count)
   );

   stack_calculator_checker #(
      .DATA_WIDTH (DATA_WIDTH),
      .DEPTH      (DEPTH)
   ) u_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_value         (req_value),
      .req_index_a       (req_index_a),
      .req_index_b       (req_index_b),
      .rsp_valid         (rsp_valid),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .rsp_element_count (rsp_element_count),
      .fail_count        (fail_count),
      .pending           (pending),
      .checked           (checked)
   );

   // called at a falling edge; returns at the falling edge where the next
   // transaction may be driven
   task automatic send(logic [OP_WIDTH-1:0] op, word_type operand,
                       logic [IDX_WIDTH-1:0] ia, logic [IDX_WIDTH-1:0] ib, int gap);
      start       <= 1'b1;
      req_op      <= op;
      req_value   <= operand;
      req_index_a <= ia;
      req_index_b <= ib;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // hold off until every outstanding response has come back
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   function automatic word_type pick_word();
      case ($urandom_range(0, 5))
         0:       return MOST_NEG;
         1:       return MOST_POS;
         2:       return '0;
         3:       return word_type'(int'($urandom_range(0, 16)) - 8);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int                   counted;
      int                   push_pct;
      int                   roll;
      int                   gap_max;
      logic [OP_WIDTH-1:0]  op;
      logic [IDX_WIDTH-1:0] ia;
      logic [IDX_WIDTH-1:0] ib;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // empty-stack guards
      send(OP_POP,  '0, '0, '0, 0);
      send(OP_PEEK, '0, '0, '0, 3);
      send(OP_DEC2, '0, '0, '0, 0);
      send(OP_ADD3, '0, '0, '0, 1);
      send(OP_SUB,  '0, '0, '0, 0);
      send(OP_SWAP, '0, '0, '0, 0);
      // one element holding zero: the binary guard counts, not the value
      send(OP_PUSH, '0, '0, '0, 0);
      send(OP_ADD,  '0, '0, '0, 2);
      // most negative divided by minus one wraps
      send(OP_PUSH, '1, '0, '0, 0);
      send(OP_PUSH, MOST_NEG, '0, '0, 0);
      send(OP_DIV,  '0, '0, '0, 0);
      send(OP_DIV,  '0, '0, '0, 5);
      send(OP_SWAP, '0, 4'd0, 4'd1, 0);
      send(OP_SWAP, '0, 4'd15, 4'd1, 0);
      send(OP_DIV,  '0, '0, '0, 0);
      // wrap on increment and decrement
      send(OP_PUSH, MOST_POS, '0, '0, 0);
      send(OP_ADD3, '0, '0, '0, 0);
      send(OP_DEC2, '0, '0, '0, 0);
      send(OP_DEC2, '0, '0, '0, 13);
      send(OP_PUSH, word_type'(3), '0, '0, 0);
      send(OP_MUL,  '0, '0, '0, 0);
      send(OP_SUB,  '0, '0, '0, 0);
      send(OP_PUSH, MOST_POS, '0, '0, 0);
      send(OP_ADD,  '0, '0, '0, 0);
      send(OP_PEEK, '0, '0, '0, 0);
      send(4'd15,   '1, 4'd15, 4'd15, 0);
      send(OP_POP,  '0, '0, '0, 0);
      drain();

      // fill past the top, then shuffle the full stack
      for (int i = 0; i <= DEPTH; i++) begin
         send(OP_PUSH, pick_word(), '0, '0, $urandom_range(0, 13));
      end
      repeat (4) begin
         send(OP_SWAP, '0, IDX_WIDTH'($urandom_range(0, 15)),
              IDX_WIDTH'($urandom_range(0, 15)), 0);
      end
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         push_pct = (ph % 3 == 0) ? 75 : (ph % 3 == 1) ? 25 : 50;
         gap_max  = (ph % 4 == 1) ? 0 : (ph % 4 == 3) ? 2 : 13;
         counted  = 0;
         while (counted < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
               op = OP_PUSH;
            end else if (roll < push_pct + 3) begin
               op = OP_WIDTH'($urandom_range(10, 15));
            end else begin
               op = OP_WIDTH'($urandom_range(OP_POP, OP_SWAP));
            end
            // lower indices hit valid swaps more often on a partly filled stack
            ia = IDX_WIDTH'($urandom_range(0, $urandom_range(0, 1) ? 15 : 7));
            ib = IDX_WIDTH'($urandom_range(0, $urandom_range(0, 1) ? 15 : 7));
            send(op, pick_word(), ia, ib, $urandom_range(0, gap_max));
            if (op <= OP_SWAP) counted++;
         end
         drain();
      end

      repeat (50) @(negedge clock);
      $display("%0d transactions sent, %0d responses checked, %0d mismatches",
               sent, checked, fail_count);
      $display("covered all opcodes and unused codes, empty and full stack, bad swap indices");
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout with %0d responses outstanding", pending);
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/sc_pkg.sv
hdl/sc_stack_ram.sv
hdl/sc_alu.sv
hdl/stack_calculator.sv
bench/stack_calculator_checker.sv
bench/stack_calculator_tb.sv
